// ===== rtl/msml_pkg.sv =====
`timescale 1ns / 1ps

package msml_pkg;

    // Stream field geometry
    localparam int SAMPLE_W    = 16;
    localparam int SRC_FIELDS  = 4;
    localparam int NUM_SOURCES = 4;
    localparam int NUM_USED    = (NUM_SOURCES < SRC_FIELDS) ? NUM_SOURCES : SRC_FIELDS;

    // Mix and gain widths
    localparam int SUM_W      = SAMPLE_W + $clog2(SRC_FIELDS);
    localparam int VOL_W      = 17;
    localparam int PROD_FRAC  = SAMPLE_W - 1 + 16;
    localparam int LIM_FRAC   = 24;
    localparam int SHIFT_DOWN = PROD_FRAC - LIM_FRAC;
    localparam int MAG_W      = SUM_W + VOL_W - SHIFT_DOWN;
    localparam int HEAD_W     = 22;
    localparam int OUT_SHIFT  = LIM_FRAC - (SAMPLE_W - 1);

    localparam logic [VOL_W-1:0]    VOL_UNITY = 17'd65536;
    localparam logic [LIM_FRAC-1:0] LIM_T     = 24'd13421773;
    localparam logic [HEAD_W-1:0]   LIM_HEAD  = 22'd3355443;
    localparam logic [MAG_W-1:0]    LIM_ONE   = MAG_W'(1) << LIM_FRAC;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAXPOS = {1'b0, {(SAMPLE_W-1){1'b1}}};

    // Configuration register map (word index)
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_VOLUME  = 2'd0;
    localparam logic [1:0] REG_MUTE    = 2'd1;
    localparam logic [1:0] REG_PLAYING = 2'd2;

    // Word handed from cell to cell in the divider row
    typedef struct packed {
        logic [MAG_W-1:0]    rem;
        logic [MAG_W-1:0]    dvs;
        logic [LIM_FRAC-1:0] quo;
        logic [LIM_FRAC-1:0] base;
        logic                neg;
        logic                last;
    } t_div_word;

endpackage

// ===== rtl/msml_front.sv =====
`timescale 1ns / 1ps

module msml_front import msml_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [SRC_FIELDS*SAMPLE_W-1:0] i_samples,
    input  logic [SRC_FIELDS-1:0]          i_mask,
    input  logic                           i_last,
    input  logic                           i_audible,
    input  logic [VOL_W-1:0]               i_volume,
    output logic                           o_valid,
    input  logic                           i_ready,
    output t_div_word                      o_data
);

    logic               r_a_valid, r_a_neg, r_a_last;
    logic [SUM_W-1:0]   r_a_mag;
    logic               r_b_valid, r_b_neg, r_b_last;
    logic [MAG_W-1:0]   r_b_mag;
    logic               r_c_valid;
    t_div_word          r_c_data;

    logic               ready_a, ready_b, ready_c;
    logic signed [SUM_W-1:0] n_sum;
    logic               n_a_neg;
    logic [SUM_W-1:0]   n_a_mag;
    logic [SUM_W+VOL_W-1:0] prod;
    logic [MAG_W-1:0]   n_b_mag;
    logic [MAG_W-1:0]   excess;
    t_div_word          n_c_data;

    assign ready_c = !r_c_valid || i_ready;
    assign ready_b = !r_b_valid || ready_c;
    assign ready_a = !r_a_valid || ready_b;
    assign o_ready = ready_a;
    assign o_valid = r_c_valid;
    assign o_data  = r_c_data;

    // Add the audible sources; a silenced stream mixes to zero
    always_comb begin
        n_sum = '0;
        for (int n = 0; n < NUM_USED; n++) begin
            if (i_mask[n] && i_audible) begin
                n_sum = n_sum + SUM_W'(signed'(i_samples[n*SAMPLE_W +: SAMPLE_W]));
            end
        end
        n_a_neg = n_sum[SUM_W-1];
        n_a_mag = n_a_neg ? SUM_W'(-n_sum) : SUM_W'(n_sum);
    end

    assign prod    = r_a_mag * i_volume;
    assign n_b_mag = prod[SHIFT_DOWN +: MAG_W];

    // Split at the knee: below it the magnitude passes, above it the excess is divided
    always_comb begin
        excess        = r_b_mag - MAG_W'(LIM_T);
        n_c_data.neg  = r_b_neg;
        n_c_data.last = r_b_last;
        n_c_data.quo  = '0;
        if (r_b_mag <= MAG_W'(LIM_T)) begin
            n_c_data.base = r_b_mag[LIM_FRAC-1:0];
            n_c_data.rem  = '0;
            n_c_data.dvs  = LIM_ONE;
        end else begin
            n_c_data.base = LIM_T;
            n_c_data.rem  = excess;
            n_c_data.dvs  = LIM_ONE + excess;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (ready_a) r_a_valid <= i_valid;
            if (ready_b) r_b_valid <= r_a_valid;
            if (ready_c) r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_valid) begin
            r_a_neg  <= n_a_neg;
            r_a_mag  <= n_a_mag;
            r_a_last <= i_last;
        end
        if (ready_b && r_a_valid) begin
            r_b_neg  <= r_a_neg;
            r_b_mag  <= n_b_mag;
            r_b_last <= r_a_last;
        end
        if (ready_c && r_b_valid) begin
            r_c_data <= n_c_data;
        end
    end

endmodule

// ===== rtl/msml_div_cell.sv =====
`timescale 1ns / 1ps

module msml_div_cell import msml_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_div_word i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_div_word o_data
);

    logic          r_valid;
    t_div_word     r_data;
    t_div_word     n_data;
    logic          ready;
    logic [MAG_W:0] twice;
    logic          fits;

    assign ready   = !r_valid || i_ready;
    assign o_ready = ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // One restoring step: double the remainder, subtract the divisor when it fits
    always_comb begin
        n_data = i_data;
        twice  = {i_data.rem, 1'b0};
        fits   = twice >= {1'b0, i_data.dvs};
        if (fits) begin
            n_data.rem = MAG_W'(twice - {1'b0, i_data.dvs});
        end else begin
            n_data.rem = twice[MAG_W-1:0];
        end
        n_data.quo = {i_data.quo[LIM_FRAC-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== rtl/msml_back.sv =====
`timescale 1ns / 1ps

module msml_back import msml_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_div_word           i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [SAMPLE_W-1:0] o_sample,
    output logic                o_last
);

    logic                    r_d_valid, r_d_neg, r_d_last;
    logic [HEAD_W-1:0]       r_d_add;
    logic [LIM_FRAC-1:0]     r_d_base;
    logic                    r_e_valid, r_e_last;
    logic [SAMPLE_W-1:0]     r_e_sample;

    logic                    ready_d, ready_e;
    logic [HEAD_W+LIM_FRAC-1:0] prod;
    logic [LIM_FRAC:0]       lim;
    logic [LIM_FRAC:0]       rnd;
    logic [SAMPLE_W-1:0]     mag;
    logic [SAMPLE_W-1:0]     n_e_sample;

    assign ready_e  = !r_e_valid || i_ready;
    assign ready_d  = !r_d_valid || ready_e;
    assign o_ready  = ready_d;
    assign o_valid  = r_e_valid;
    assign o_sample = r_e_sample;
    assign o_last   = r_e_last;

    assign prod = LIM_HEAD * i_data.quo;

    // Round the Q.24 magnitude half up, clip positive full scale, restore the sign
    always_comb begin
        lim = {1'b0, r_d_base} + (LIM_FRAC+1)'(r_d_add);
        rnd = lim + ((LIM_FRAC+1)'(1) << (OUT_SHIFT - 1));
        mag = rnd[OUT_SHIFT +: SAMPLE_W];
        if (r_d_neg) begin
            n_e_sample = SAMPLE_W'(-mag);
        end else if (mag > SAMPLE_MAXPOS) begin
            n_e_sample = SAMPLE_MAXPOS;
        end else begin
            n_e_sample = mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            if (ready_d) r_d_valid <= i_valid;
            if (ready_e) r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_d && i_valid) begin
            r_d_add  <= prod[LIM_FRAC +: HEAD_W];
            r_d_base <= i_data.base;
            r_d_neg  <= i_data.neg;
            r_d_last <= i_data.last;
        end
        if (ready_e && r_d_valid) begin
            r_e_sample <= n_e_sample;
            r_e_last   <= r_d_last;
        end
    end

endmodule

// ===== rtl/multi_source_mixer_soft_limiter.sv =====
// Four-source audio mixer with volume and soft limiter.
// Input stream: s_axis_tdata carries four signed 16-bit samples, source 0 in
// the low bits; s_axis_tuser is the 4-bit mask of audible sources; s_axis_tlast
// marks the last sample of a buffer and comes back on m_axis_tlast.
// Output stream: m_axis_tdata is the mixed, scaled, limited 16-bit sample.
// Registers on the APB port: 0x0 volume (Q1.16, writes above unity clamp to
// unity), 0x4 mute, 0x8 playing. Output is zero while muted or stopped.
// The path: registered mix, gain and knee split stages, a row of 24
// divider cells that each resolve one quotient bit of the limiter curve, then
// a scaling register, then rounding and sign restore into the output register.
// Throughput is one sample per cycle when not stalled. Each stage holds its
// transaction when the next one is full, so a stall at m_axis_tready fills the
// empty stages first and s_axis_tready drops only when every stage holds a sample.
// Reset empties the pipeline and sets volume to unity, mute off, playing off.
// Write registers only while the pipeline is empty.
`timescale 1ns / 1ps

module multi_source_mixer_soft_limiter import msml_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // src0_sample, src1_sample, src2_sample, src3_sample
    input  logic [SRC_FIELDS*SAMPLE_W-1:0] s_axis_tdata,
    // source_mask
    input  logic [SRC_FIELDS-1:0]          s_axis_tuser,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // mixed_sample
    output logic [SAMPLE_W-1:0]            m_axis_tdata,
    output logic                           m_axis_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ADDR_W-1:0]              paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic [VOL_W-1:0] r_volume;
    logic             r_mute;
    logic             r_playing;
    logic [VOL_W-1:0] n_volume;
    logic             wr_en;
    logic [1:0]       reg_idx;

    t_div_word        cell_data  [0:LIM_FRAC];
    logic             cell_valid [0:LIM_FRAC];
    logic             cell_ready [0:LIM_FRAC];

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign n_volume = (pwdata[VOL_W-1:0] > VOL_UNITY) ? VOL_UNITY : pwdata[VOL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume  <= VOL_UNITY;
            r_mute    <= 1'b0;
            r_playing <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_VOLUME:  r_volume  <= n_volume;
                REG_MUTE:    r_mute    <= pwdata[0];
                REG_PLAYING: r_playing <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_VOLUME:  prdata = 32'(r_volume);
            REG_MUTE:    prdata = 32'(r_mute);
            REG_PLAYING: prdata = 32'(r_playing);
            default:     prdata = '0;
        endcase
    end

    msml_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_samples (s_axis_tdata),
        .i_mask    (s_axis_tuser),
        .i_last    (s_axis_tlast),
        .i_audible (r_playing && !r_mute),
        .i_volume  (r_volume),
        .o_valid   (cell_valid[0]),
        .i_ready   (cell_ready[0]),
        .o_data    (cell_data[0])
    );

    for (genvar k = 0; k < LIM_FRAC; k++) begin : g_cell
        msml_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cell_valid[k]),
            .o_ready (cell_ready[k]),
            .i_data  (cell_data[k]),
            .o_valid (cell_valid[k+1]),
            .i_ready (cell_ready[k+1]),
            .o_data  (cell_data[k+1])
        );
    end

    msml_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (cell_valid[LIM_FRAC]),
        .o_ready  (cell_ready[LIM_FRAC]),
        .i_data   (cell_data[LIM_FRAC]),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_sample (m_axis_tdata),
        .o_last   (m_axis_tlast)
    );

endmodule
